FILE: rtl/pixel_channel_mask_converter_unit_defines.svh
`ifndef PIXEL_CHANNEL_MASK_CONVERTER_UNIT_DEFINES_SVH
`define PIXEL_CHANNEL_MASK_CONVERTER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PCMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcmc check failed");

// Condition that must hold on every clock edge outside reset.
`define PCMC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pcmc check failed");

`endif

FILE: rtl/pcmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcmc_pkg;
    localparam int PIXEL_WIDTH = 32;
    localparam logic [31:0] PIX_MASK = 32'((64'd1 << PIXEL_WIDTH) - 64'd1);
    localparam int DIV_BITS = 2;
    localparam int DIV_STAGES = 32 / DIV_BITS;
    // Multiply stage, divider stages, output register.
    localparam int LATENCY = DIV_STAGES + 2;

    localparam logic [2:0] REG_SRC_ALPHA = 3'd0;
    localparam logic [2:0] REG_SRC_RED   = 3'd1;
    localparam logic [2:0] REG_SRC_GREEN = 3'd2;
    localparam logic [2:0] REG_SRC_BLUE  = 3'd3;
    localparam logic [2:0] REG_DST_ALPHA = 3'd4;
    localparam logic [2:0] REG_DST_RED   = 3'd5;
    localparam logic [2:0] REG_DST_GREEN = 3'd6;
    localparam logic [2:0] REG_DST_BLUE  = 3'd7;
endpackage
`default_nettype wire

FILE: rtl/pcmc_channel.sv
`timescale 1ns / 1ps
`default_nettype none
module pcmc_channel
    import pcmc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [31:0] pix,
    input  wire logic [31:0] sm,
    input  wire logic [31:0] dm,
    input  wire logic        is_alpha,
    output logic             out_valid,
    output logic [31:0]      result
);
    logic        vld_reg [0:DIV_STAGES];
    logic [31:0] rem_reg [0:DIV_STAGES];
    logic [31:0] lo_reg  [0:DIV_STAGES];
    logic [31:0] q_reg   [0:DIV_STAGES];
    logic [31:0] rem_next [1:DIV_STAGES];
    logic [31:0] lo_next  [1:DIV_STAGES];
    logic [31:0] q_next   [1:DIV_STAGES];
    logic [63:0] prod;

    assign prod = {32'd0, pix & sm} * {32'd0, dm};

    // Each stage retires DIV_BITS quotient bits. The remainder stays below sm
    // whenever sm is nonzero, since the quotient cannot exceed dm.
    always_comb
    begin
        logic [32:0] t;
        logic [31:0] r;
        logic [31:0] lo;
        logic [31:0] q;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            r  = rem_reg[k-1];
            lo = lo_reg[k-1];
            q  = q_reg[k-1];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                t  = {r, lo[31]};
                lo = {lo[30:0], 1'b0};
                if (t >= {1'b0, sm})
                begin
                    t = t - {1'b0, sm};
                    q = {q[30:0], 1'b1};
                end
                else
                begin
                    q = {q[30:0], 1'b0};
                end
                r = t[31:0];
            end
            rem_next[k] = r;
            lo_next[k]  = lo;
            q_next[k]   = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rem_reg[0] <= prod[63:32];
            lo_reg[0]  <= prod[31:0];
            q_reg[0]   <= 32'd0;
        end
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            if (vld_reg[k-1])
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES];

    always_comb
    begin
        if (sm == 32'd0)
        begin
            result = is_alpha ? dm : 32'd0;
        end
        else
        begin
            result = q_reg[DIV_STAGES] & dm;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pixel_channel_mask_converter_unit.sv
// Throughput: one pixel per clock; busy stays low, so start may be held every cycle.
// Each channel has one 32x32 multiply stage and a 16-stage divider, 2 bits a stage.
// The receiver cannot stall; done is a one-cycle strobe with dst_pixel.
// Reset clears all valid bits and loads the default ARGB 8888 masks.
`timescale 1ns / 1ps
`default_nettype none
module pixel_channel_mask_converter_unit
    import pcmc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] src_pixel,
    output logic             done,
    output logic [31:0]      dst_pixel,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [31:0] mask_reg [0:7];
    logic [3:0]  ch_valid;
    logic [31:0] ch_result [0:3];
    logic        done_reg;
    logic [31:0] dst_reg;
    logic        accept;
    logic        wr_en;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[REG_SRC_ALPHA] <= 32'hff000000;
            mask_reg[REG_SRC_RED]   <= 32'h00ff0000;
            mask_reg[REG_SRC_GREEN] <= 32'h0000ff00;
            mask_reg[REG_SRC_BLUE]  <= 32'h000000ff;
            mask_reg[REG_DST_ALPHA] <= 32'hff000000;
            mask_reg[REG_DST_RED]   <= 32'h00ff0000;
            mask_reg[REG_DST_GREEN] <= 32'h0000ff00;
            mask_reg[REG_DST_BLUE]  <= 32'h000000ff;
        end
        else if (wr_en)
        begin
            mask_reg[paddr[4:2]] <= pwdata;
        end
    end

    assign prdata = mask_reg[paddr[4:2]];

    for (genvar c = 0; c < 4; c++)
    begin : g_ch
        pcmc_channel u_ch (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (accept),
            .pix       (src_pixel),
            .sm        (mask_reg[c]),
            .dm        (mask_reg[c + 4]),
            .is_alpha  (c == 0),
            .out_valid (ch_valid[c]),
            .result    (ch_result[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= &ch_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (&ch_valid)
        begin
            dst_reg <= (ch_result[0] | ch_result[1] | ch_result[2] | ch_result[3])
                       & PIX_MASK;
        end
    end

    assign done      = done_reg;
    assign dst_pixel = dst_reg;
endmodule
`default_nettype wire

FILE: rtl/pcmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_channel_mask_converter_unit_defines.svh"
module pcmc_checker
    import pcmc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic pready
);
    // Every request produces its pixel a fixed number of cycles later.
    `PCMC_ASSERT_IMPL(a_req_done, clk, rst_n, start && !busy, ##LATENCY done)
    // No result appears without a request that caused it.
    `PCMC_ASSERT_IMPL(a_done_req, clk, rst_n, done, $past(start && !busy, LATENCY))
    `PCMC_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `PCMC_ASSERT_ALWAYS(a_ready, clk, rst_n, pready)
endmodule

bind pixel_channel_mask_converter_unit pcmc_checker u_pcmc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);
`default_nettype wire
